// ----- hw/rtl/ecpm_pkg.sv -----
// ----------------------------------------------------------------------------
// ecpm_pkg
// Shared types and constants for the edge count period meter: payload
// structs, controller states and the command/status groups.
// ----------------------------------------------------------------------------
package ecpm_pkg;

  // number of measured channels and capture word width
  localparam int CHANNELS = 4;
  localparam int CAP_W    = 24;
  localparam int CH_W     = 2;

  // divider step counter width
  localparam int DIV_CNT_W = $clog2(CAP_W);

  typedef logic [CAP_W-1:0] cap_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    cap_t            edge_time;
    cap_t            edge_count;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] channel_out;
    cap_t            current_count;
    cap_t            period;
    cap_t            edges_since_last;
    logic            period_updated;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/edge_count_period_meter.sv -----
// ----------------------------------------------------------------------------
// edge_count_period_meter
// Multi-channel frequency input meter: per channel, the time and edge count
// differences since the previous capture and the average period per edge.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | in_data  (channel, edge_time, edge_count)
//  out     | out_valid / out_ready| out_data (channel_out, current_count,
//          |                      |   period, edges_since_last, period_updated)
//
//  an item whose edge count moved passes transfer, 24 restoring divider steps,
//  a state that sees the divider done, and the result load; one that did not
//  goes from transfer straight to load; one item is in work at a time
//  a new item is taken while the previous result still waits in the output
//  register; the load waits while that register is full and stalled
//  synchronous reset clears all channel state to zero
// ----------------------------------------------------------------------------
module edge_count_period_meter (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ecpm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ecpm_pkg::out_t out_data
);

  ecpm_pkg::cmd_t    cmd;
  ecpm_pkg::status_t st;

  // sequencer
  ecpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // channel state, divider and result register
  ecpm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/ecpm_div.sv -----
// ----------------------------------------------------------------------------
// ecpm_div
// Restoring unsigned divider, one quotient bit per cycle. Operands are
// taken on start; busy stays high until the last quotient bit is formed.
// ----------------------------------------------------------------------------
module ecpm_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ecpm_pkg::cap_t dividend,
  input  ecpm_pkg::cap_t divisor,
  output logic          busy,
  output ecpm_pkg::cap_t quotient
);

  localparam int W = ecpm_pkg::CAP_W;

  logic [W-1:0]                   rem;
  logic [W-1:0]                   quo;
  logic [W-1:0]                   dvs;
  logic [ecpm_pkg::DIV_CNT_W-1:0] cnt;
  logic [W:0]                     rem_sh;
  logic [W:0]                     diff;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, quo[W-1]};
    diff   = rem_sh - {1'b0, dvs};
  end

  // step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ecpm_pkg::DIV_CNT_W'(W - 1);
    end else if (busy) begin
      cnt <= cnt - ecpm_pkg::DIV_CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= rem_sh[W-1:0];
      end
      quo <= {quo[W-2:0], ~diff[W]};
    end
  end

  assign quotient = quo;

endmodule

// ----- hw/rtl/ecpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ecpm_ctrl
// Sequencer: takes an item, waits for the divider when the count moved,
// then loads the result register once it is free.
// ----------------------------------------------------------------------------
module ecpm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ecpm_pkg::status_t st,
  output ecpm_pkg::cmd_t    cmd
);

  ecpm_pkg::state_t state;
  ecpm_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ecpm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = st.need_div ? ecpm_pkg::ST_DIV : ecpm_pkg::ST_LOAD;
        end
      end
      ecpm_pkg::ST_DIV: begin
        if (!st.div_busy) begin
          state_next = ecpm_pkg::ST_LOAD;
        end
      end
      ecpm_pkg::ST_LOAD: begin
        if (st.out_free) begin
          cmd.load   = 1'b1;
          state_next = ecpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ecpm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ecpm_dp.sv -----
// ----------------------------------------------------------------------------
// ecpm_dp
// Datapath: per-channel last time, last count and period, the modular
// differences, the divider and the result register.
// ----------------------------------------------------------------------------
module ecpm_dp (
  input  logic              clk,
  input  logic              rst,
  input  ecpm_pkg::in_t     in_data,
  input  ecpm_pkg::cmd_t    cmd,
  output ecpm_pkg::status_t st,
  output logic              out_valid,
  input  logic              out_ready,
  output ecpm_pkg::out_t    out_data
);

  localparam int NCH = ecpm_pkg::CHANNELS;

  ecpm_pkg::cap_t last_count   [NCH];
  ecpm_pkg::cap_t last_time    [NCH];
  ecpm_pkg::cap_t period_store [NCH];

  logic [ecpm_pkg::CH_W-1:0] ch_in;
  logic                      ch_in_ok;
  ecpm_pkg::cap_t            dc;
  ecpm_pkg::cap_t            dt;

  logic [ecpm_pkg::CH_W-1:0] ch;
  logic                      ch_ok;
  logic                      upd;
  ecpm_pkg::cap_t            cnt;
  ecpm_pkg::cap_t            dc_r;

  logic                      div_busy;
  ecpm_pkg::cap_t            quotient;
  ecpm_pkg::cap_t            period_new;

  // modular differences against the stored channel values
  always_comb begin
    ch_in    = in_data.channel;
    ch_in_ok = (32'(ch_in) < 32'(NCH));
    if (ch_in_ok) begin
      dc = in_data.edge_count - last_count[ch_in];
      dt = in_data.edge_time  - last_time[ch_in];
    end else begin
      dc = '0;
      dt = '0;
    end
  end

  ecpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept && (dc != '0)),
    .dividend (dt),
    .divisor  (dc),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // item context held while the divider runs
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch    <= ch_in;
      ch_ok <= ch_in_ok;
      upd   <= (dc != '0);
      cnt   <= in_data.edge_count;
      dc_r  <= dc;
    end
  end

  // channel state; reset clears all entries
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        last_count[i]   <= '0;
        last_time[i]    <= '0;
        period_store[i] <= '0;
      end
    end else begin
      if (cmd.accept && ch_in_ok) begin
        last_count[ch_in] <= in_data.edge_count;
        last_time[ch_in]  <= in_data.edge_time;
      end
      if (cmd.load && ch_ok && upd) begin
        period_store[ch] <= quotient;
      end
    end
  end

  assign period_new = upd ? quotient : period_store[ch];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.channel_out <= ch;
      if (ch_ok) begin
        out_data.current_count    <= cnt;
        out_data.period           <= period_new;
        out_data.edges_since_last <= dc_r;
        out_data.period_updated   <= upd;
      end else begin
        out_data.current_count    <= '0;
        out_data.period           <= '0;
        out_data.edges_since_last <= '0;
        out_data.period_updated   <= 1'b0;
      end
    end
  end

  // status back to the controller
  always_comb begin
    st.need_div = (dc != '0);
    st.div_busy = div_busy;
    st.out_free = !out_valid || out_ready;
  end

endmodule

// ----- hw/rtl/ecpm_checker.sv -----
// ----------------------------------------------------------------------------
// ecpm_checker
// Port-level checks for the edge count period meter, bound to the top level.
// ----------------------------------------------------------------------------
module ecpm_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ecpm_pkg::out_t out_data
);

  // one item in work: no transfer right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

  // a result never shows up in the cycle right after an input transfer
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // period recomputed exactly when edges moved
  a_upd_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.edges_since_last != '0) == out_data.period_updated))
    else $error("period_updated disagrees with edges_since_last");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind edge_count_period_meter ecpm_checker u_ecpm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
